// ----- rtl/core/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque: request and status
// codes, field widths, and the command/status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  // Payload widths
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REJ_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJ_EMPTY  = 2'd2;

  // Front/back value reported for an empty deque
  localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic exec;      // apply the request to indices, count and ring
    logic fill;      // reload front/back cache from ring read data
    logic load;      // move the result into the output register
  } cdq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic needs_fill; // request exposes a new end element that must be read
  } cdq_stat_t;

endpackage : cdq_pkg

`default_nettype wire

// ----- rtl/core/cdq_req_if.sv -----
// ----------------------------------------------------------------------------
// cdq_req_if
// Request channel: valid/ready handshake carrying request type and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_req_if;

  logic                          valid;
  logic                          ready;
  logic [cdq_pkg::REQ_W-1:0]     req_type;
  logic signed [cdq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);

endinterface : cdq_req_if

`default_nettype wire

// ----- rtl/core/cdq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cdq_rsp_if
// Result channel: valid/ready handshake carrying status, popped value,
// fill count and the front/back values.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_rsp_if;

  logic                              valid;
  logic                              ready;
  logic [cdq_pkg::STATUS_W-1:0]      status;
  logic signed [cdq_pkg::DATA_W-1:0] popped_value;
  logic [cdq_pkg::FILL_W-1:0]        fill_count;
  logic signed [cdq_pkg::DATA_W-1:0] front_value;
  logic signed [cdq_pkg::DATA_W-1:0] back_value;

  modport source (output valid, output status, output popped_value, output fill_count,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input status, input popped_value, input fill_count,
                  input front_value, input back_value, output ready);

endinterface : cdq_rsp_if

`default_nettype wire

// ----- rtl/core/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencing state machine: takes a request, runs the update, an optional
// ring read to refresh a cached end value, then hands the result to the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cdq_pkg::cdq_cmd_t      cmd,
  input  wire cdq_pkg::cdq_stat_t stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Command decode
  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd.capture = (state == ST_IDLE) && in_valid;
    cmd.exec    = (state == ST_EXEC);
    cmd.fill    = (state == ST_FILL);
    cmd.load    = (state == ST_DONE) && (!out_valid || out_ready);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = stat.needs_fill ? ST_FILL : ST_DONE;
      end
      ST_FILL: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Output register holds until its transfer completes
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule : cdq_ctrl

`default_nettype wire

// ----- rtl/core/cdq_datapath.sv -----
// ----------------------------------------------------------------------------
// cdq_datapath
// Ring memory, head/tail indices, element count, cached front/back values
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_datapath #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire cdq_pkg::cdq_cmd_t                cmd,
  output cdq_pkg::cdq_stat_t                    stat,
  input  wire logic [cdq_pkg::REQ_W-1:0]        req_type,
  input  wire logic signed [cdq_pkg::DATA_W-1:0] push_value,
  output logic [cdq_pkg::STATUS_W-1:0]          status,
  output logic signed [cdq_pkg::DATA_W-1:0]     popped_value,
  output logic [cdq_pkg::FILL_W-1:0]            fill_count,
  output logic signed [cdq_pkg::DATA_W-1:0]     front_value,
  output logic signed [cdq_pkg::DATA_W-1:0]     back_value
);

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int XW = (CW > cdq_pkg::FILL_W) ? CW : cdq_pkg::FILL_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(RING_DEPTH);

  // Ring storage and registered read port
  logic [cdq_pkg::DATA_W-1:0] ring [RING_DEPTH];
  logic [cdq_pkg::DATA_W-1:0] rd_data;

  // Latched request
  logic [cdq_pkg::REQ_W-1:0]  req_r;
  logic [cdq_pkg::DATA_W-1:0] val_r;

  // Deque state
  logic [IW-1:0]              head;
  logic [IW-1:0]              tail;
  logic [CW-1:0]              count;
  logic [cdq_pkg::DATA_W-1:0] front_r;
  logic [cdq_pkg::DATA_W-1:0] back_r;

  // Per-request result
  logic [cdq_pkg::STATUS_W-1:0] status_r;
  logic [cdq_pkg::DATA_W-1:0]   popped_r;

  // Execute-step decode
  logic                         empty;
  logic                         full;
  logic                         single;
  logic [IW-1:0]                head_inc;
  logic [IW-1:0]                head_dec;
  logic [IW-1:0]                tail_inc;
  logic [IW-1:0]                tail_dec;
  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  logic [IW-1:0]                rd_addr;
  logic [XW-1:0]                count_x;

  assign empty  = (count == '0);
  assign full   = (count == FULL_CNT);
  assign single = (count == CW'(1));

  assign head_inc = (head == LAST_IDX) ? '0 : head + IW'(1);
  assign head_dec = (head == '0) ? LAST_IDX : head - IW'(1);
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + IW'(1);
  assign tail_dec = (tail == '0) ? LAST_IDX : tail - IW'(1);

  // Write target of a push; an empty deque is written in place
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head;
    case (req_r)
      cdq_pkg::REQ_PUSH_FRONT: begin
        wr_en   = !full;
        wr_addr = empty ? head : head_dec;
      end
      cdq_pkg::REQ_PUSH_BACK: begin
        wr_en   = !full;
        wr_addr = empty ? tail : tail_inc;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // A pop that leaves elements behind exposes a new end element
  assign rd_addr = (req_r == cdq_pkg::REQ_POP_FRONT) ? head_inc : tail_dec;
  assign stat.needs_fill = !req_r[1] ? 1'b0 : (!empty && !single);

  // Ring memory
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      ring[wr_addr] <= val_r;
    end
    rd_data <= ring[rd_addr];
  end

  // Request latch (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= req_type;
      val_r <= push_value;
    end
  end

  // Indices and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      case (req_r)
        cdq_pkg::REQ_PUSH_FRONT: begin
          if (!full) begin
            head  <= wr_addr;
            count <= count + CW'(1);
          end
        end
        cdq_pkg::REQ_PUSH_BACK: begin
          if (!full) begin
            tail  <= wr_addr;
            count <= count + CW'(1);
          end
        end
        cdq_pkg::REQ_POP_FRONT: begin
          if (!empty) begin
            if (!single) head <= head_inc;
            count <= count - CW'(1);
          end
        end
        default: begin
          if (!empty) begin
            if (!single) tail <= tail_dec;
            count <= count - CW'(1);
          end
        end
      endcase
    end
  end

  // Cached end values and per-request result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= cdq_pkg::STAT_DONE;
      popped_r <= '0;
      case (req_r)
        cdq_pkg::REQ_PUSH_FRONT: begin
          if (full) begin
            status_r <= cdq_pkg::STAT_REJ_FULL;
          end else begin
            front_r <= val_r;
            if (empty) back_r <= val_r;
          end
        end
        cdq_pkg::REQ_PUSH_BACK: begin
          if (full) begin
            status_r <= cdq_pkg::STAT_REJ_FULL;
          end else begin
            back_r <= val_r;
            if (empty) front_r <= val_r;
          end
        end
        cdq_pkg::REQ_POP_FRONT: begin
          if (empty) status_r <= cdq_pkg::STAT_REJ_EMPTY;
          else       popped_r <= front_r;
        end
        default: begin
          if (empty) status_r <= cdq_pkg::STAT_REJ_EMPTY;
          else       popped_r <= back_r;
        end
      endcase
    end else if (cmd.fill) begin
      if (req_r == cdq_pkg::REQ_POP_FRONT) front_r <= rd_data;
      else                                 back_r  <= rd_data;
    end
  end

  // Result register
  assign count_x = XW'(count);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status       <= status_r;
      popped_value <= popped_r;
      fill_count   <= count_x[cdq_pkg::FILL_W-1:0];
      front_value  <= empty ? cdq_pkg::EMPTY_VALUE : front_r;
      back_value   <= empty ? cdq_pkg::EMPTY_VALUE : back_r;
    end
  end

endmodule : cdq_datapath

`default_nettype wire

// ----- rtl/core/circular_deque.sv -----
// Circular deque: one request in, one result out.
// Each request is latched, executed and loaded into the result register;
// a pop that leaves elements behind adds a ring read between execute and
// load that refreshes the cached front or back value.
// A new request is taken only once the previous result has been loaded.
// Reset (rst, synchronous): deque empty, indices zero, result channel idle.
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a ring of RING_DEPTH 32-bit entries, built from a
// sequencing controller and a datapath with the ring memory.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cdq_req_if.sink    req,
  cdq_rsp_if.source  rsp
);

  cdq_pkg::cdq_cmd_t  cmd;
  cdq_pkg::cdq_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cdq_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req.req_type),
    .push_value   (req.push_value),
    .status       (rsp.status),
    .popped_value (rsp.popped_value),
    .fill_count   (rsp.fill_count),
    .front_value  (rsp.front_value),
    .back_value   (rsp.back_value)
  );

endmodule : circular_deque

`default_nettype wire
